// ----- rtl/core/ptw_pkg.sv -----
// Package for the four-level page table walker.
// Holds field widths, item codes, entry bit positions and the index helper.
// No dependencies.
`default_nettype none

package ptw_pkg;

  // Field widths of the two channels.
  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned OUT_PA_W = 56;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;

  // Input item codes.
  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_RESPONSE = 1'b1;

  // Result item codes.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Page size codes.
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // Entry bit positions.
  localparam int unsigned ENT_PRESENT_BIT = 0;
  localparam int unsigned ENT_HUGE_BIT    = 7;

  // Table level that the next entry belongs to, top first.
  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  // Nine-bit table index of a virtual address for one level.
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input level_t lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ptw_in_if.sv -----
// Input channel of the page table walker: requests and memory responses.
// Depends on ptw_pkg for field widths.
`default_nettype none

interface ptw_in_if
  import ptw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               func;
  logic [VA_W-1:0]    vaddr;
  logic [PA_W-1:0]    root_base;
  logic [ENTRY_W-1:0] entry_data;

  modport source (output valid, func, vaddr, root_base, entry_data, input ready);
  modport sink   (input valid, func, vaddr, root_base, entry_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptw_out_if.sv -----
// Output channel of the page table walker: entry reads and finished walks.
// Depends on ptw_pkg for field widths.
`default_nettype none

interface ptw_out_if
  import ptw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [PA_W-1:0]     read_addr;
  logic                mapped;
  logic [OUT_PA_W-1:0] phys_addr;
  logic [1:0]          map_size;

  modport source (output valid, kind, read_addr, mapped, phys_addr, map_size,
                  input ready);
  modport sink   (input valid, kind, read_addr, mapped, phys_addr, map_size,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/four_level_page_table_walker.sv -----
// Four-level page table walker, top level.
// Depends on ptw_pkg, ptw_in_if and ptw_out_if.
//
//   channel   direction  beat content
//   items     in         request (vaddr, root_base) or response (entry_data)
//   results   out        entry read (read_addr) or walk done (mapped, phys_addr,
//                        map_size)
//
// Every accepted beat is decoded in the cycle it arrives, and its result, if
// any, sits in the output register from the next cycle on: one beat per cycle.
// A walk takes one request beat plus one response beat for each level visited.
// Reset (synchronous) clears the walk state and the output register valid.
// The input stalls only while the output register holds a beat that the sink
// does not take; that one register sets the rate.
`default_nettype none

module four_level_page_table_walker
  import ptw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  ptw_in_if.sink     items,
  ptw_out_if.source  results
);

  // Walk state.
  logic            walk_busy;
  logic            walk_busy_next;
  level_t          walk_level;
  level_t          walk_level_next;
  logic [VA_W-1:0] saved_vaddr;
  logic [VA_W-1:0] saved_vaddr_next;

  // Output register.
  logic                out_valid;
  logic                out_kind;
  logic [PA_W-1:0]     out_read_addr;
  logic                out_mapped;
  logic [OUT_PA_W-1:0] out_phys_addr;
  logic [1:0]          out_map_size;

  // Result of the beat at the input.
  logic                res_valid;
  logic                res_kind;
  logic [PA_W-1:0]     res_read_addr;
  logic                res_mapped;
  logic [OUT_PA_W-1:0] res_phys_addr;
  logic [1:0]          res_map_size;

  logic   take;
  level_t lvl_up;

  assign items.ready = !out_valid || results.ready;
  assign take        = items.valid && items.ready;
  assign lvl_up      = level_t'(walk_level + 2'd1);

  // Decode one beat against the walk state.
  always_comb begin
    walk_busy_next   = walk_busy;
    walk_level_next  = walk_level;
    saved_vaddr_next = saved_vaddr;
    res_valid        = 1'b0;
    res_kind         = KIND_READ;
    res_read_addr    = '0;
    res_mapped       = 1'b0;
    res_phys_addr    = '0;
    res_map_size     = SIZE_4K;

    priority if (items.func == FUNC_REQUEST) begin
      // A request always starts a fresh walk at the top table.
      walk_busy_next   = 1'b1;
      walk_level_next  = LVL_PML4;
      saved_vaddr_next = items.vaddr;
      res_valid        = 1'b1;
      res_read_addr    = {items.root_base[PA_W-1:12],
                          level_index(items.vaddr, LVL_PML4), 3'b000};
    end else if (walk_busy) begin
      res_valid = 1'b1;
      priority if (!items.entry_data[ENT_PRESENT_BIT]) begin
        res_kind        = KIND_DONE;
        walk_busy_next  = 1'b0;
        walk_level_next = LVL_PML4;
      end else if (walk_level == LVL_PDPT && items.entry_data[ENT_HUGE_BIT]) begin
        res_kind        = KIND_DONE;
        res_mapped      = 1'b1;
        res_phys_addr   = {4'b0000, items.entry_data[51:30], saved_vaddr[29:0]};
        res_map_size    = SIZE_1G;
        walk_busy_next  = 1'b0;
        walk_level_next = LVL_PML4;
      end else if (walk_level == LVL_PD && items.entry_data[ENT_HUGE_BIT]) begin
        res_kind        = KIND_DONE;
        res_mapped      = 1'b1;
        res_phys_addr   = {4'b0000, items.entry_data[51:21], saved_vaddr[20:0]};
        res_map_size    = SIZE_2M;
        walk_busy_next  = 1'b0;
        walk_level_next = LVL_PML4;
      end else if (walk_level == LVL_PT) begin
        res_kind        = KIND_DONE;
        res_mapped      = 1'b1;
        res_phys_addr   = {4'b0000, items.entry_data[51:12], saved_vaddr[11:0]};
        res_map_size    = SIZE_4K;
        walk_busy_next  = 1'b0;
        walk_level_next = LVL_PML4;
      end else begin
        // Descend one level: the entry holds the next table base.
        walk_level_next = lvl_up;
        res_read_addr   = {items.entry_data[51:12],
                           level_index(saved_vaddr, lvl_up), 3'b000};
      end
    end else begin
      // Response with no walk in progress is dropped.
      res_valid = 1'b0;
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy   <= 1'b0;
      walk_level  <= LVL_PML4;
      saved_vaddr <= '0;
    end else if (take) begin
      walk_busy   <= walk_busy_next;
      walk_level  <= walk_level_next;
      saved_vaddr <= saved_vaddr_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_kind      <= res_kind;
      out_read_addr <= res_read_addr;
      out_mapped    <= res_mapped;
      out_phys_addr <= res_phys_addr;
      out_map_size  <= res_map_size;
    end
  end

  assign results.valid     = out_valid;
  assign results.kind      = out_kind;
  assign results.read_addr = out_read_addr;
  assign results.mapped    = out_mapped;
  assign results.phys_addr = out_phys_addr;
  assign results.map_size  = out_map_size;

endmodule

`default_nettype wire

// ----- rtl/core/ptw_checker.sv -----
// Port-level checks for the four-level page table walker, and their bind.
// Depends on ptw_pkg and on the top level four_level_page_table_walker.
`default_nettype none

module ptw_checker
  import ptw_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            in_func,
  input wire logic [VA_W-1:0] in_vaddr,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            out_kind,
  input wire logic [PA_W-1:0] out_read_addr
);

  // A result beat waits until the sink takes it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A request beat yields a top-level entry read in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_REQUEST |=>
      out_valid && out_kind == KIND_READ &&
      out_read_addr[11:3] == $past(in_vaddr[47:39]))
    else $error("request did not produce the top-level entry read");

  // The input stalls only behind a held result beat.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the output free");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_func       (items.func),
  .in_vaddr      (items.vaddr),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_kind      (results.kind),
  .out_read_addr (results.read_addr)
);

`default_nettype wire
